FILE: sv/acms_pkg.sv
// Shared constants, types and helpers for the augmented count-min sketch.
package acms_pkg;

    // Sketch geometry; ROW_WIDTH must be a power of two (index is a mask of the hash)
    localparam int ROWS         = 4;
    localparam int ROW_WIDTH    = 1024;
    localparam int FILTER_SLOTS = 32;

    localparam int SLOT_W    = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W     = $clog2(ROW_WIDTH);
    localparam int MEM_AW    = ROW_W + IDX_W;
    localparam int MEM_DEPTH = ROWS * ROW_WIDTH;

    // Counters never exceed the signed 32-bit maximum, so 31 bits hold them
    localparam int CNT_W = 31;
    typedef logic [CNT_W-1:0] t_cnt;
    localparam t_cnt CNT_MAX = '1;

    // Hash constants
    localparam logic [31:0] HC1  = 32'hcc9e2d51;
    localparam logic [31:0] HC2  = 32'h1b873593;
    localparam logic [31:0] HADD = 32'he6546b64;
    localparam logic [31:0] HC3  = 32'h85ebca6b;
    localparam logic [31:0] HC4  = 32'hc2b2ae35;

    // Saturating counter add
    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

FILE: sv/augmented_count_min_sketch.sv
// Augmented count-min sketch: hot-key filter in front of a hashed counter memory.
// One transaction at a time. After reset the block runs a clearing pass over
// all ROWS*ROW_WIDTH = 4096 sketch memory words with the input stalled.
// Every transaction first scans the filter one slot per cycle, then makes a
// decision. A filter hit or a fill of an empty slot ends there. Otherwise a
// sketch pass follows: key mixing (K1, K2), then per row 3 hash stages and
// one read-modify-write on the counter memory, which has separate read and
// write ports. An eviction with positive gain adds a second pass for the
// evicted key. A query result sits in an output register until taken; the
// next transaction is accepted meanwhile.
module augmented_count_min_sketch (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic signed [31:0]        i_key,
    input  logic [15:0]               i_amount,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [acms_pkg::CNT_W-1:0] o_estimate
);
    import acms_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DEC, S_K1, S_K2, S_H1, S_H2, S_H3, S_RD, S_OUT
    } t_state;

    t_state r_state;

    // Filter storage
    logic [31:0] r_fkey [FILTER_SLOTS];
    t_cnt        r_fnew [FILTER_SLOTS];
    t_cnt        r_fold [FILTER_SLOTS];

    // Sketch memory
    t_cnt r_mem [MEM_DEPTH];
    t_cnt r_rdata;

    // Transaction registers
    logic              r_kind;
    logic [31:0]       r_key;
    t_cnt              r_amt;
    logic [SLOT_W-1:0] r_idx;
    logic              r_hit, r_emp;
    logic [SLOT_W-1:0] r_hit_slot, r_emp_slot, r_min_slot;
    t_cnt              r_hit_cnt, r_min, r_min_old;
    logic [31:0]       r_min_key;

    // Row pass registers
    logic [31:0]       r_pkey;
    t_cnt              r_addamt;
    logic              r_wr;
    logic              r_pass;
    logic [ROW_W-1:0]  r_row;
    logic [31:0]       r_k, r_h;
    logic [MEM_AW-1:0] r_addr;
    logic [MEM_AW-1:0] r_clr;
    t_cnt              r_est;
    t_cnt              r_res;

    logic              r_ovalid;
    logic              n_ovalid;
    t_cnt              r_est_out;

    // Combinational helpers
    logic [31:0]       w_skey, w_t0, w_t1, w_t2, w_h2, w_h3;
    logic [MEM_AW-1:0] w_ra;
    t_cnt              w_sum, w_val, n_est;
    logic              w_we;
    logic [MEM_AW-1:0] w_wa;
    t_cnt              w_wd;

    assign w_skey = r_fkey[r_idx];

    // First hash stage: seed mix, rotate, scale, finalize shift
    always_comb begin
        w_t0 = {{(32-ROW_W){1'b0}}, r_row} ^ r_k;
        w_t1 = {w_t0[18:0], w_t0[31:19]};
        w_t1 = ((w_t1 << 2) + w_t1 + HADD) ^ 32'd4;
        w_t2 = w_t1 ^ (w_t1 >> 16);
    end

    assign w_h2 = r_h ^ (r_h >> 13);
    assign w_h3 = r_h ^ (r_h >> 16);
    assign w_ra = {r_row, w_h3[IDX_W-1:0]};

    // Modify step of the row pass
    assign w_sum = sat_add(r_rdata, r_addamt);
    assign w_val = r_wr ? w_sum : r_rdata;
    assign n_est = (w_val < r_est) ? w_val : r_est;

    // Memory write port select
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = w_sum;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else if (r_state == S_RD) begin
            w_we = r_wr;
        end
    end

    // Sketch memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    // Output valid: set when a result is loaded, cleared when taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_estimate = r_est_out;

    // Sequencer, filter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < FILTER_SLOTS; i++) begin
                r_fkey[i] <= '0;
                r_fnew[i] <= '0;
                r_fold[i] <= '0;
            end
        end else begin
            r_ovalid <= n_ovalid;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MEM_AW'(MEM_DEPTH-1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_key   <= i_key;
                        r_amt   <= CNT_W'(i_amount);
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_emp   <= 1'b0;
                        r_min   <= CNT_MAX;
                        r_state <= S_SCAN;
                    end
                end
                // One filter slot per cycle: first match, first empty, minimum
                S_SCAN: begin
                    if (!r_hit && w_skey == r_key) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_idx;
                        r_hit_cnt  <= r_fnew[r_idx];
                    end
                    if (!r_emp && w_skey == '0) begin
                        r_emp      <= 1'b1;
                        r_emp_slot <= r_idx;
                    end
                    if (r_fnew[r_idx] < r_min) begin
                        r_min      <= r_fnew[r_idx];
                        r_min_slot <= r_idx;
                        r_min_old  <= r_fold[r_idx];
                        r_min_key  <= w_skey;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(FILTER_SLOTS-1)) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_hit && r_kind) begin
                        r_res   <= r_hit_cnt;
                        r_state <= S_OUT;
                    end else if (r_hit) begin
                        r_fnew[r_hit_slot] <= sat_add(r_hit_cnt, r_amt);
                        r_state <= S_IDLE;
                    end else if (!r_kind && r_emp) begin
                        r_fkey[r_emp_slot] <= r_key;
                        r_fnew[r_emp_slot] <= r_amt;
                        r_fold[r_emp_slot] <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_pkey   <= r_key;
                        r_addamt <= r_kind ? '0 : r_amt;
                        r_wr     <= !r_kind;
                        r_pass   <= 1'b0;
                        r_est    <= CNT_MAX;
                        r_state  <= S_K1;
                    end
                end
                // Key mixing, shared by all rows
                S_K1: begin
                    r_k     <= r_pkey * HC1;
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_k     <= {r_k[16:0], r_k[31:17]} * HC2;
                    r_row   <= '0;
                    r_state <= S_H1;
                end
                S_H1: begin
                    r_h     <= w_t2 * HC3;
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_h     <= w_h2 * HC4;
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_addr  <= w_ra;
                    r_state <= S_RD;
                end
                // Read data back: add and write when inserting, track the row minimum on the first pass
                S_RD: begin
                    if (!r_pass) begin
                        r_est <= n_est;
                    end
                    if (r_row != ROW_W'(ROWS-1)) begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_H1;
                    end else if (r_pass) begin
                        r_fkey[r_min_slot] <= r_key;
                        r_fnew[r_min_slot] <= r_est;
                        r_fold[r_min_slot] <= r_est;
                        r_state <= S_IDLE;
                    end else if (r_kind) begin
                        r_res   <= n_est;
                        r_state <= S_OUT;
                    end else if (r_min != CNT_MAX && n_est > r_min) begin
                        if (r_min > r_min_old) begin
                            r_pkey   <= r_min_key;
                            r_addamt <= r_min - r_min_old;
                            r_wr     <= 1'b1;
                            r_pass   <= 1'b1;
                            r_state  <= S_K1;
                        end else begin
                            r_fkey[r_min_slot] <= r_key;
                            r_fnew[r_min_slot] <= n_est;
                            r_fold[r_min_slot] <= n_est;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // Wait for the output register to free up
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_est_out <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/acms_chk.sv
// Port-level checker for the augmented count-min sketch, bound to the top level.
module acms_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [acms_pkg::CNT_W-1:0] o_estimate
);
    import acms_pkg::*;

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_estimate))
        else $error("stalled result changed");

    // No result can appear the cycle after a transaction is taken
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result without filter scan");

    // A new result is only produced while the input side was busy
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result produced while idle");

endmodule

bind augmented_count_min_sketch acms_chk u_acms_chk (.*);

FILE: verif/augmented_count_min_sketch_test.sv
// Self-checking testbench for the augmented count-min sketch.
`timescale 1ns / 1ps

module augmented_count_min_sketch_test;
    import acms_pkg::*;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam int   N_RANDOM    = 900;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   DRAIN_WAIT  = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_kind;
    logic [31:0] i_key;
    logic [15:0] i_amount;
    logic        o_valid;
    logic        i_stall;
    t_cnt        o_estimate;

    augmented_count_min_sketch dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_key(i_key), .i_amount(i_amount),
        .o_valid(o_valid), .i_stall(i_stall), .o_estimate(o_estimate)
    );

    // Shadow state of the sketch
    logic [31:0] shadow_sketch[MEM_DEPTH];
    logic [31:0] shadow_key[FILTER_SLOTS];
    logic [31:0] shadow_new[FILTER_SLOTS];
    logic [31:0] shadow_old[FILTER_SLOTS];

    t_cnt estimate_queue[$];
    int   mismatch_count;
    int   cycle_count;
    bit   stim_done;
    bit   hold_rx;
    bit   quiet_idle;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] hash_word(input logic [31:0] key,
                                              input logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        k = key * 32'hcc9e2d51;
        k = rotl(k, 15);
        k = k * 32'h1b873593;
        h = seed ^ k;
        h = rotl(h, 13);
        h = h * 32'd5 + 32'he6546b64;
        h = h ^ 32'd4;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int counter_addr(input logic [31:0] key, input int row);
        return row * ROW_WIDTH + int'(hash_word(key, row) % ROW_WIDTH);
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > 33'h7fffffff) ? 32'h7fffffff : s[31:0];
    endfunction

    // Frequency estimate of a key: filter count or minimum over rows
    function automatic logic [31:0] estimate_of(input logic [31:0] key);
        logic [31:0] m;
        m = 32'h7fffffff;
        for (int i = 0; i < FILTER_SLOTS; i++)
            if (shadow_key[i] == key) return shadow_new[i];
        for (int r = 0; r < ROWS; r++)
            if (shadow_sketch[counter_addr(key, r)] < m)
                m = shadow_sketch[counter_addr(key, r)];
        return m;
    endfunction

    // Insert into the shadow filter/sketch, with eviction
    task automatic insert_key(input logic [31:0] key, input logic [31:0] amt);
        logic [31:0] min_cnt;
        logic [31:0] est;
        logic [31:0] gain;
        int          min_pos;
        int          p;
        bit          have_min;
        min_cnt = 32'h7fffffff;
        est = 32'h7fffffff;
        min_pos = 0;
        have_min = 1'b0;
        for (int i = 0; i < FILTER_SLOTS; i++)
            if (shadow_key[i] == key) begin
                shadow_new[i] = add_sat(shadow_new[i], amt);
                return;
            end
        for (int i = 0; i < FILTER_SLOTS; i++) begin
            if (shadow_key[i] == 32'd0) begin
                shadow_new[i] = amt;
                shadow_old[i] = 32'd0;
                shadow_key[i] = key;
                return;
            end
            if (min_cnt > shadow_new[i]) begin
                min_cnt = shadow_new[i];
                min_pos = i;
                have_min = 1'b1;
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            p = counter_addr(key, r);
            shadow_sketch[p] = add_sat(shadow_sketch[p], amt);
            if (shadow_sketch[p] < est) est = shadow_sketch[p];
        end
        if (have_min && est > min_cnt) begin
            if (shadow_new[min_pos] > shadow_old[min_pos]) begin
                gain = shadow_new[min_pos] - shadow_old[min_pos];
                for (int r = 0; r < ROWS; r++) begin
                    p = counter_addr(shadow_key[min_pos], r);
                    shadow_sketch[p] = add_sat(shadow_sketch[p], gain);
                end
            end
            shadow_key[min_pos] = key;
            shadow_new[min_pos] = est;
            shadow_old[min_pos] = est;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_rx || (!quiet_idle && $urandom_range(99) < 8);
    end

    // Result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (estimate_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: estimate %0d", o_estimate);
            end else begin
                if (o_estimate !== estimate_queue[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("estimate mismatch: expected %0d got %0d",
                                 estimate_queue[0], o_estimate);
                end
                void'(estimate_queue.pop_front());
            end
        end
    end

    // Long receiver hold-off, counted in cycles here
    initial begin
        hold_rx = 1'b0;
        wait (stim_done == 1'b0 && cycle_count > 8000);
        @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // Send one item; check is by prediction, which a typed value checks when given.
    // Valid stays high after the handshake so the next call can follow back to back.
    task automatic send_item(input logic kind, input logic [31:0] key,
                             input logic [15:0] amt, input bit fixed,
                             input logic [31:0] fixed_est);
        logic [31:0] est;
        while (!quiet_idle && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_key <= key;
        i_amount <= amt;
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_QUERY) begin
            est = estimate_of(key);
            if (fixed && est != fixed_est) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("directed row disagrees: expected %0d predicted %0d",
                             fixed_est, est);
            end
            estimate_queue.push_back(est[CNT_W-1:0]);
        end else begin
            insert_key(key, {16'd0, amt});
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (estimate_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [15:0] amt;
        bit          fixed;
        logic [31:0] est;
    } t_dir_row;

    t_dir_row dir_rows[] = '{
        '{KIND_QUERY,  32'h0000_0005, 16'd0,     1'b1, 32'd0},       // after reset
        '{KIND_QUERY,  32'h0000_0000, 16'd0,     1'b1, 32'd0},
        '{KIND_INSERT, 32'h0000_0000, 16'd7,     1'b0, 32'd0},       // key zero
        '{KIND_QUERY,  32'h0000_0000, 16'd0,     1'b1, 32'd7},
        '{KIND_INSERT, 32'h8000_0000, 16'hffff,  1'b0, 32'd0},
        '{KIND_QUERY,  32'h8000_0000, 16'd0,     1'b1, 32'd65535},
        '{KIND_QUERY,  32'h0000_0000, 16'd0,     1'b1, 32'd0},
        '{KIND_INSERT, 32'h7fff_ffff, 16'd0,     1'b0, 32'd0},
        '{KIND_INSERT, 32'hffff_ffff, 16'd1,     1'b0, 32'd0},
        '{KIND_QUERY,  32'hffff_ffff, 16'hffff,  1'b1, 32'd1},
        '{KIND_QUERY,  32'h7fff_ffff, 16'd0,     1'b1, 32'd0},
        '{KIND_INSERT, 32'h8000_0000, 16'hffff,  1'b0, 32'd0},
        '{KIND_QUERY,  32'h8000_0000, 16'd0,     1'b1, 32'd131070}
    };

    logic [31:0] key_pool[64];
    logic [31:0] k;

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_key = 32'd0;
        i_amount = 16'd0;
        stim_done = 1'b0;
        quiet_idle = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        foreach (shadow_sketch[i]) shadow_sketch[i] = 32'd0;
        for (int i = 0; i < FILTER_SLOTS; i++) begin
            shadow_key[i] = 32'd0;
            shadow_new[i] = 32'd0;
            shadow_old[i] = 32'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].amt,
                      dir_rows[i].fixed, dir_rows[i].est);

        // Fill the filter, then push it into eviction with more keys than it has slots
        for (int i = 0; i < 40; i++)
            send_item(KIND_INSERT, 32'h100 + 32'(i), 16'd3, 1'b0, 32'd0);
        for (int i = 0; i < 6; i++)
            send_item(KIND_QUERY, 32'h100 + 32'd30 + 32'(i), 16'd0, 1'b0, 32'd0);

        // Heavy inserts on one key with the largest amount
        for (int i = 0; i < 6; i++)
            send_item(KIND_INSERT, 32'h0000_0105, 16'hffff, 1'b0, 32'd0);
        for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'd0;

        // Sender pause until all results are in
        wait_drained();

        // Random traffic, mostly from a hot key pool so hits and evictions occur
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) wait_drained();
            quiet_idle = (n >= 500 && n < 650);
            if ($urandom_range(99) < 70) k = key_pool[$urandom_range(63)];
            else k = $urandom;
            if ($urandom_range(99) < 45)
                send_item(KIND_QUERY, k, 16'($urandom), 1'b0, 32'd0);
            else if ($urandom_range(99) < 3)
                send_item(KIND_INSERT, k, 16'hffff, 1'b0, 32'd0);
            else
                send_item(KIND_INSERT, k, ($urandom_range(3) == 0) ? 16'($urandom)
                          : 16'($urandom_range(20)), 1'b0, 32'd0);
        end
        quiet_idle = 1'b0;
        stim_done = 1'b1;

        wait_drained();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Leftover expectations show up as a timeout in wait_drained
endmodule

FILE: files.f
sv/acms_pkg.sv
sv/augmented_count_min_sketch.sv
sv/acms_chk.sv
verif/augmented_count_min_sketch_test.sv
